// ----- rtl/core/mmsp_pkg.sv -----
// Shared types and constants for the serial mouse packet encoder.
`timescale 1ns / 1ps

package mmsp_pkg;

   typedef enum logic {
      MODE_MOVE = 1'b0,
      MODE_TICK = 1'b1
   } mode_type;

   // Configuration register indexes
   localparam logic CSR_WHEEL_MODE = 1'b0;
   localparam logic CSR_DUTY_SKIP  = 1'b1;

   localparam int CSR_DATA_BITS = 2;

   // Movement clamps per report
   localparam int XY_LO = -128;
   localparam int XY_HI = 127;
   localparam int Z_LO  = -8;
   localparam int Z_HI  = 7;

   // First byte always carries the sync bit at bit 6
   localparam logic [1:0] HEAD_SYNC = 2'b01;

   typedef struct packed {
      mode_type          mode;
      logic [7:0]        status_byte;
      logic [7:0]        move_x;
      logic [7:0]        move_y;
      logic [7:0]        move_z;
   } req_word_type;

   typedef struct packed {
      logic              load;
      logic              wide;
      logic [3:0][7:0]   bytes;
   } pkt_type;

endpackage

// ----- rtl/core/mmsp_if.sv -----
// Handshake interfaces for the request and response channels.
`timescale 1ns / 1ps

interface mmsp_req_if;
   logic              valid;
   logic              ready;
   logic              mode;
   logic [7:0]        status_byte;
   logic signed [7:0] move_x;
   logic signed [7:0] move_y;
   logic signed [7:0] move_z;

   modport source (output valid, mode, status_byte, move_x, move_y, move_z,
                   input ready);
   modport sink   (input valid, mode, status_byte, move_x, move_y, move_z,
                   output ready);
endinterface

interface mmsp_rsp_if;
   logic              valid;
   logic              ready;
   logic [7:0]        serial_byte;
   logic              last_byte;

   modport source (output valid, serial_byte, last_byte, input ready);
   modport sink   (input valid, serial_byte, last_byte, output ready);
endinterface

// ----- rtl/core/mmsp_encode.sv -----
// Button and motion accumulators, report phase and packet formation.
`timescale 1ns / 1ps

module mmsp_encode #(
   parameter int ACC_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic                                    csr_index,
   input  logic [mmsp_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   input  logic                                    take,
   input  mmsp_pkg::req_word_type                  word,
   output mmsp_pkg::pkt_type                       pkt
);

   localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
   localparam logic signed [ACC_BITS-1:0] XY_LO = ACC_BITS'(mmsp_pkg::XY_LO);
   localparam logic signed [ACC_BITS-1:0] XY_HI = ACC_BITS'(mmsp_pkg::XY_HI);
   localparam logic signed [ACC_BITS-1:0] Z_LO  = ACC_BITS'(mmsp_pkg::Z_LO);
   localparam logic signed [ACC_BITS-1:0] Z_HI  = ACC_BITS'(mmsp_pkg::Z_HI);

   logic                       wheel_mode_ff, wheel_mode_in;
   logic [1:0]                 duty_skip_ff, duty_skip_in;
   logic [2:0]                 pending_ff, pending_in;
   logic [2:0]                 sent_ff, sent_in;
   logic signed [ACC_BITS-1:0] acc_x_ff, acc_x_in;
   logic signed [ACC_BITS-1:0] acc_y_ff, acc_y_in;
   logic signed [ACC_BITS-1:0] acc_z_ff, acc_z_in;
   logic [1:0]                 phase_ff, phase_in;

   logic signed [ACC_BITS:0]   sum_x, sum_y, sum_z;
   logic signed [ACC_BITS-1:0] sat_x, sat_y, sat_z;
   logic signed [ACC_BITS-1:0] clip_x, clip_y, clip_z;
   logic [1:0]                 phase_next;
   logic                       report;

   always_comb begin
      sum_x = {acc_x_ff[ACC_BITS-1], acc_x_ff} + (ACC_BITS+1)'($signed(word.move_x));
      sum_y = {acc_y_ff[ACC_BITS-1], acc_y_ff} - (ACC_BITS+1)'($signed(word.move_y));
      sum_z = {acc_z_ff[ACC_BITS-1], acc_z_ff} + (ACC_BITS+1)'($signed(word.move_z));

      // Saturate where the extra sign bit disagrees with the top bit
      if (sum_x[ACC_BITS] != sum_x[ACC_BITS-1]) begin
         sat_x = sum_x[ACC_BITS] ? ACC_MIN : ACC_MAX;
      end else begin
         sat_x = sum_x[ACC_BITS-1:0];
      end
      if (sum_y[ACC_BITS] != sum_y[ACC_BITS-1]) begin
         sat_y = sum_y[ACC_BITS] ? ACC_MIN : ACC_MAX;
      end else begin
         sat_y = sum_y[ACC_BITS-1:0];
      end
      if (sum_z[ACC_BITS] != sum_z[ACC_BITS-1]) begin
         sat_z = sum_z[ACC_BITS] ? ACC_MIN : ACC_MAX;
      end else begin
         sat_z = sum_z[ACC_BITS-1:0];
      end

      if (acc_x_ff < XY_LO) begin
         clip_x = XY_LO;
      end else if (acc_x_ff > XY_HI) begin
         clip_x = XY_HI;
      end else begin
         clip_x = acc_x_ff;
      end
      if (acc_y_ff < XY_LO) begin
         clip_y = XY_LO;
      end else if (acc_y_ff > XY_HI) begin
         clip_y = XY_HI;
      end else begin
         clip_y = acc_y_ff;
      end
      if (acc_z_ff < Z_LO) begin
         clip_z = Z_LO;
      end else if (acc_z_ff > Z_HI) begin
         clip_z = Z_HI;
      end else begin
         clip_z = acc_z_ff;
      end

      phase_next = phase_ff + 2'd1;
      report = (phase_next >= duty_skip_ff) &&
               ((pending_ff != sent_ff) || (acc_x_ff != '0) ||
                (acc_y_ff != '0) || (acc_z_ff != '0));

      wheel_mode_in = wheel_mode_ff;
      duty_skip_in  = duty_skip_ff;
      pending_in    = pending_ff;
      sent_in       = sent_ff;
      acc_x_in      = acc_x_ff;
      acc_y_in      = acc_y_ff;
      acc_z_in      = acc_z_ff;
      phase_in      = phase_ff;

      if (csr_we) begin
         case (csr_index)
            mmsp_pkg::CSR_WHEEL_MODE: wheel_mode_in = csr_wdata[0];
            mmsp_pkg::CSR_DUTY_SKIP:  duty_skip_in  = csr_wdata[1:0];
            default:                  ;
         endcase
      end

      pkt.load  = 1'b0;
      pkt.wide  = wheel_mode_ff;
      pkt.bytes[0] = {mmsp_pkg::HEAD_SYNC, pending_ff[0], pending_ff[1],
                      clip_y[7:6], clip_x[7:6]};
      pkt.bytes[1] = {2'b00, clip_x[5:0]};
      pkt.bytes[2] = {2'b00, clip_y[5:0]};
      pkt.bytes[3] = {3'b000, pending_ff[2], clip_z[3:0]};

      if (take) begin
         case (word.mode)
            mmsp_pkg::MODE_MOVE: begin
               pending_in = word.status_byte[2:0];
               acc_x_in   = sat_x;
               acc_y_in   = sat_y;
               if (wheel_mode_ff) begin
                  acc_z_in = sat_z;
               end
            end
            mmsp_pkg::MODE_TICK: begin
               phase_in = phase_next;
               if (report) begin
                  pkt.load = 1'b1;
                  acc_x_in = acc_x_ff - clip_x;
                  acc_y_in = acc_y_ff - clip_y;
                  acc_z_in = acc_z_ff - clip_z;
                  sent_in  = pending_ff;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_mode_ff <= 1'b0;
         duty_skip_ff  <= '0;
         pending_ff    <= '0;
         sent_ff       <= '0;
         acc_x_ff      <= '0;
         acc_y_ff      <= '0;
         acc_z_ff      <= '0;
         phase_ff      <= '0;
      end else begin
         wheel_mode_ff <= wheel_mode_in;
         duty_skip_ff  <= duty_skip_in;
         pending_ff    <= pending_in;
         sent_ff       <= sent_in;
         acc_x_ff      <= acc_x_in;
         acc_y_ff      <= acc_y_in;
         acc_z_ff      <= acc_z_in;
         phase_ff      <= phase_in;
      end
   end

endmodule

// ----- rtl/core/mmsp_serial.sv -----
// Packet buffer that hands out one packet byte per response word.
`timescale 1ns / 1ps

module mmsp_serial (
   input  logic                 clock,
   input  logic                 reset,
   input  mmsp_pkg::pkt_type    pkt,
   output logic                 free,
   mmsp_rsp_if.source           rsp_if
);

   logic             busy_ff, busy_in;
   logic [1:0]       idx_ff, idx_in;
   logic             wide_ff, wide_in;
   logic [3:0][7:0]  bytes_ff, bytes_in;
   logic             last;

   always_comb begin
      last = wide_ff ? (idx_ff == 2'd3) : (idx_ff == 2'd2);
      free = !busy_ff || (last && rsp_if.ready);

      busy_in  = busy_ff;
      idx_in   = idx_ff;
      wide_in  = wide_ff;
      bytes_in = bytes_ff;

      // Advance on each taken word, drop the packet after its last byte
      if (busy_ff && rsp_if.ready) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
      if (pkt.load) begin
         busy_in  = 1'b1;
         idx_in   = '0;
         wide_in  = pkt.wide;
         bytes_in = pkt.bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      wide_ff  <= wide_in;
      bytes_ff <= bytes_in;
   end

   assign rsp_if.valid       = busy_ff;
   assign rsp_if.serial_byte = bytes_ff[idx_ff];
   assign rsp_if.last_byte   = last;

endmodule

// ----- rtl/core/mouse_motion_to_serial_mouse_packets_top.sv -----
// Top level of the serial mouse packet encoder.
//
//   port     role     carries
//   req_if   sink     mode, status_byte, move_x, move_y, move_z
//   rsp_if   source   serial_byte, last_byte (one byte per word)
//   csr_*    write    index 0 wheel_mode, index 1 duty_skip
//
// A request word is registered, then worked from that register. A movement
// word never waits; any tick waits until the packet buffer is free or gives
// out its last byte in that cycle. A reporting tick fills the buffer, which
// sends 3 or 4 bytes at one byte per cycle while rsp_if is ready. Stalls
// hold the byte shown. Synchronous reset clears all but the data buffers.
`timescale 1ns / 1ps

module mouse_motion_to_serial_mouse_packets_top #(
   parameter int ACC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   mmsp_req_if.sink                            req_if,
   mmsp_rsp_if.source                          rsp_if,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [mmsp_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   logic                    in_valid_ff, in_valid_in;
   mmsp_pkg::req_word_type  in_word_ff, in_word_in;
   logic                    take;
   logic                    ser_free;
   mmsp_pkg::pkt_type       pkt;

   always_comb begin
      // A tick needs the packet buffer; a movement word never does
      take = in_valid_ff && ((in_word_ff.mode == mmsp_pkg::MODE_MOVE) || ser_free);
      req_if.ready = !in_valid_ff || take;

      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (take) begin
         in_valid_in = 1'b0;
      end
      if (req_if.valid && req_if.ready) begin
         in_valid_in            = 1'b1;
         in_word_in.mode        = mmsp_pkg::mode_type'(req_if.mode);
         in_word_in.status_byte = req_if.status_byte;
         in_word_in.move_x      = req_if.move_x;
         in_word_in.move_y      = req_if.move_y;
         in_word_in.move_z      = req_if.move_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
   end

   mmsp_encode #(
      .ACC_BITS (ACC_BITS)
   ) u_encode (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .take      (take),
      .word      (in_word_ff),
      .pkt       (pkt)
   );

   mmsp_serial u_serial (
      .clock  (clock),
      .reset  (reset),
      .pkt    (pkt),
      .free   (ser_free),
      .rsp_if (rsp_if)
   );

endmodule

// ----- tb/mouse_motion_to_serial_mouse_packets_top_tb.sv -----
// Testbench for the serial mouse packet encoder, checked against a local encoder model.
`timescale 1ns / 1ps

module mouse_motion_to_serial_mouse_packets_top_tb;

   localparam int ACC_BITS     = 16;
   localparam int ACC_MAX      = 2 ** (ACC_BITS - 1) - 1;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400000;

   localparam int STALL_NONE    = 0;
   localparam int STALL_RANDOM  = 1;
   localparam int STALL_PATTERN = 2;

   typedef struct packed {
      logic [7:0] serial_byte;
      logic       last_byte;
   } serial_word_type;

   logic                                clock;
   logic                                reset;
   logic                                csr_we;
   logic                                csr_index;
   logic [mmsp_pkg::CSR_DATA_BITS-1:0]  csr_wdata;

   mmsp_req_if req_bus ();
   mmsp_rsp_if rsp_bus ();

   mouse_motion_to_serial_mouse_packets_top #(
      .ACC_BITS (ACC_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Encoder model state
   logic       wheel_on;
   logic [1:0] skip_ticks;
   logic [2:0] btn_pending;
   logic [2:0] btn_reported;
   int         sum_x;
   int         sum_y;
   int         sum_z;
   logic [1:0] tick_phase;

   serial_word_type serial_words_due[$];
   int              error_count;

   // Traffic shaping
   bit         send_idle;
   int         burst_left;
   int         stall_style;
   int         hold_cycles;
   logic [7:0] stall_pattern;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("mouse_motion_to_serial_mouse_packets_top test failed");
      $finish;
   end

   function automatic int clamp_to(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int saturate_sum(input int v);
      return clamp_to(v, -ACC_MAX - 1, ACC_MAX);
   endfunction

   // Update the model for one accepted word and queue the bytes it reports.
   function automatic void encode_word(input mmsp_pkg::mode_type kind,
                                       input logic [7:0] status,
                                       input logic signed [7:0] mx,
                                       input logic signed [7:0] my,
                                       input logic signed [7:0] mz);
      int         cx;
      int         cy;
      int         cz;
      logic [7:0] bx;
      logic [7:0] by;
      logic [7:0] bz;
      if (kind == mmsp_pkg::MODE_MOVE) begin
         btn_pending = status[2:0];
         sum_x = saturate_sum(sum_x + mx);
         sum_y = saturate_sum(sum_y - my);
         if (wheel_on) sum_z = saturate_sum(sum_z + mz);
         return;
      end
      tick_phase = tick_phase + 2'd1;
      if (tick_phase < skip_ticks) return;
      if (btn_pending == btn_reported && sum_x == 0 && sum_y == 0 && sum_z == 0) return;
      cx = clamp_to(sum_x, mmsp_pkg::XY_LO, mmsp_pkg::XY_HI);
      cy = clamp_to(sum_y, mmsp_pkg::XY_LO, mmsp_pkg::XY_HI);
      cz = clamp_to(sum_z, mmsp_pkg::Z_LO, mmsp_pkg::Z_HI);
      sum_x -= cx;
      sum_y -= cy;
      // Z drains even with the wheel off; only the fourth byte is dropped
      sum_z -= cz;
      btn_reported = btn_pending;
      bx = cx[7:0];
      by = cy[7:0];
      bz = cz[7:0];
      serial_words_due.push_back({mmsp_pkg::HEAD_SYNC, btn_pending[0], btn_pending[1],
                                  by[7:6], bx[7:6], 1'b0});
      serial_words_due.push_back({2'b00, bx[5:0], 1'b0});
      serial_words_due.push_back({2'b00, by[5:0], !wheel_on});
      if (wheel_on) serial_words_due.push_back({3'b000, btn_pending[2], bz[3:0], 1'b1});
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      serial_word_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (serial_words_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected byte %02h", rsp_bus.serial_byte));
         end else begin
            want = serial_words_due.pop_front();
            if (rsp_bus.serial_byte !== want.serial_byte)
               flag_mismatch($sformatf("serial_byte %02h, want %02h",
                                       rsp_bus.serial_byte, want.serial_byte));
            if (rsp_bus.last_byte !== want.last_byte)
               flag_mismatch($sformatf("last_byte %b, want %b",
                                       rsp_bus.last_byte, want.last_byte));
         end
      end
   end

   // Receiver: long hold-off first, else the stall style of the phase.
   initial begin
      rsp_bus.ready = 1'b0;
      stall_pattern = 8'b1101_0110;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_bus.ready = 1'b0;
         end else begin
            case (stall_style)
               STALL_NONE: begin
                  rsp_bus.ready = 1'b1;
               end
               STALL_RANDOM: begin
                  rsp_bus.ready = ($urandom_range(0, 2) != 0);
               end
               default: begin
                  stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
                  rsp_bus.ready = stall_pattern[0];
               end
            endcase
         end
      end
   end

   // Offer one word from a falling edge; return at a falling edge after it is taken.
   task automatic send_word(input mmsp_pkg::mode_type kind, input logic [7:0] status,
                            input logic [7:0] mx, input logic [7:0] my,
                            input logic [7:0] mz);
      req_bus.valid       = 1'b1;
      req_bus.mode        = kind;
      req_bus.status_byte = status;
      req_bus.move_x      = mx;
      req_bus.move_y      = my;
      req_bus.move_z      = mz;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      encode_word(kind, status, mx, my, mz);
      @(negedge clock);
      if (send_idle) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 12);
            req_bus.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   endtask

   task automatic send_move(input logic [7:0] status, input logic [7:0] mx,
                            input logic [7:0] my, input logic [7:0] mz);
      send_word(mmsp_pkg::MODE_MOVE, status, mx, my, mz);
   endtask

   // Tick payload is don't-care for the block; keep it busy anyway.
   task automatic send_tick();
      send_word(mmsp_pkg::MODE_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom));
   endtask

   // Drop valid, wait for every queued byte, then let the pipeline settle.
   task automatic wait_drained();
      req_bus.valid = 1'b0;
      while (serial_words_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx,
                            input logic [mmsp_pkg::CSR_DATA_BITS-1:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         mmsp_pkg::CSR_WHEEL_MODE: wheel_on = value[0];
         default:                  skip_ticks = value;
      endcase
   endtask

   task automatic drain_motion();
      int guard;
      guard = 0;
      while ((sum_x != 0 || sum_y != 0 || sum_z != 0 || btn_pending != btn_reported) &&
             guard < 5000) begin
         send_tick();
         guard++;
      end
   endtask

   function automatic logic [7:0] pick_move();
      case ($urandom_range(0, 7))
         0:       return 8'h80;
         1:       return 8'h7F;
         2:       return 8'h00;
         3:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic test_field_extremes();
      write_csr(mmsp_pkg::CSR_WHEEL_MODE, 2'd1);
      write_csr(mmsp_pkg::CSR_DUTY_SKIP, 2'd0);
      // upper status bits must be dropped
      send_move(8'hFF, 8'h7F, 8'h80, 8'h7F);
      send_tick();
      send_tick();
      send_move(8'hF8, 8'h80, 8'h7F, 8'h80);
      send_tick();
      send_tick();
      // button change alone reports
      send_move(8'h02, 8'h00, 8'h00, 8'h00);
      send_tick();
      send_tick();
      send_move(8'h04, 8'h01, 8'hFF, 8'hF9);
      send_tick();
      send_move(8'h01, 8'h40, 8'hC0, 8'h08);
      send_tick();
      drain_motion();
      wait_drained();
      // wheel off: move_z ignored, three-byte packets
      write_csr(mmsp_pkg::CSR_WHEEL_MODE, 2'd0);
      send_move(8'h03, 8'h00, 8'h00, 8'h7F);
      send_tick();
      send_move(8'h00, 8'h7F, 8'h7F, 8'h80);
      send_tick();
      drain_motion();
      wait_drained();
   endtask

   task automatic test_duty_settings();
      for (int d = 0; d < 4; d++) begin
         write_csr(mmsp_pkg::CSR_DUTY_SKIP, 2'(d));
         repeat (2) send_move(8'($urandom), 8'h7F, 8'h80, pick_move());
         repeat (8) send_tick();
         drain_motion();
         wait_drained();
      end
   endtask

   task automatic test_wheel_leftover();
      write_csr(mmsp_pkg::CSR_WHEEL_MODE, 2'd1);
      write_csr(mmsp_pkg::CSR_DUTY_SKIP, 2'd0);
      send_move(8'h04, 8'h00, 8'h00, 8'h14);
      send_move(8'h04, 8'h00, 8'h00, 8'h14);
      wait_drained();
      write_csr(mmsp_pkg::CSR_WHEEL_MODE, 2'd0);
      drain_motion();
      wait_drained();
   endtask

   // X and Z pile up to the low limit, Y to the high limit.
   task automatic test_saturation();
      write_csr(mmsp_pkg::CSR_WHEEL_MODE, 2'd1);
      write_csr(mmsp_pkg::CSR_DUTY_SKIP, 2'd0);
      repeat (258) send_move(8'($urandom), 8'h80, 8'h80, 8'h80);
      repeat (3) send_tick();
      wait_drained();
   endtask

   task automatic test_backpressure();
      send_idle   = 1'b0;
      stall_style = STALL_NONE;
      hold_cycles = 300;
      repeat (15) begin
         send_move(8'($urandom), pick_move(), pick_move(), pick_move());
         send_tick();
      end
      wait_drained();
   endtask

   task automatic run_random_phase(input logic wheel, input logic [1:0] duty,
                                   input bit idle, input int stall, input int count);
      write_csr(mmsp_pkg::CSR_WHEEL_MODE, {1'b0, wheel});
      write_csr(mmsp_pkg::CSR_DUTY_SKIP, duty);
      send_idle   = idle;
      stall_style = stall;
      repeat (count) begin
         if ($urandom_range(0, 9) < 6)
            send_move(8'($urandom), pick_move(), pick_move(), pick_move());
         else
            send_tick();
      end
      wait_drained();
   endtask

   task automatic test_random();
      run_random_phase(1'b1, 2'd0, 1'b1, STALL_RANDOM, 12);
      run_random_phase(1'b0, 2'd2, 1'b0, STALL_PATTERN, 12);
      run_random_phase(1'b1, 2'd3, 1'b1, STALL_NONE, 12);
      run_random_phase(1'b0, 2'd1, 1'b1, STALL_PATTERN, 12);
   endtask

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = mmsp_pkg::CSR_WHEEL_MODE;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.mode        = mmsp_pkg::MODE_MOVE;
      req_bus.status_byte = 8'h00;
      req_bus.move_x      = 8'h00;
      req_bus.move_y      = 8'h00;
      req_bus.move_z      = 8'h00;
      wheel_on     = 1'b0;
      skip_ticks   = 2'd0;
      btn_pending  = 3'd0;
      btn_reported = 3'd0;
      sum_x        = 0;
      sum_y        = 0;
      sum_z        = 0;
      tick_phase   = 2'd0;
      error_count  = 0;
      send_idle    = 1'b1;
      burst_left   = 0;
      stall_style  = STALL_RANDOM;
      hold_cycles  = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_field_extremes();
      test_duty_settings();
      test_wheel_leftover();
      test_backpressure();
      test_random();
      test_saturation();

      if (error_count == 0)
         $display("mouse_motion_to_serial_mouse_packets_top test passed");
      else
         $display("mouse_motion_to_serial_mouse_packets_top test failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/mmsp_pkg.sv
rtl/core/mmsp_if.sv
rtl/core/mmsp_encode.sv
rtl/core/mmsp_serial.sv
rtl/core/mouse_motion_to_serial_mouse_packets_top.sv
tb/mouse_motion_to_serial_mouse_packets_top_tb.sv
